>>> rtl/bcss_pkg.sv
package bcss_pkg;

   // Store and group sizes.
   localparam int MAX_SAMPLES = 256;
   localparam int CANDIDATES_PER_SAMPLE = 8;

   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SLOT_W = $clog2(CANDIDATES_PER_SAMPLE);

   // Field widths fixed by the interface.
   localparam int COMP_W = 16;
   localparam int DIR_W = 3 * COMP_W;
   localparam int INDEX_W = 8;
   localparam int TOTAL_W = 9;
   localparam int SCORE_W = 32;
   localparam int PROD_W = 2 * COMP_W;
   localparam int SUM_W = PROD_W + 2;

   localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(256);

   // Score given to a candidate with no stored sample: -1.0 in Q3.28.
   localparam logic signed [SCORE_W-1:0] SCORE_MINUS_ONE = -(SCORE_W'(1) <<< 28);

   // Register map, by register index.
   localparam logic REG_SAMPLE_TOTAL = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic decide;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic scan_done;
      logic pipe_empty;
      logic group_close;
      logic out_free;
   } status_type;

endpackage

>>> rtl/bcss_ctrl.sv
module bcss_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  bcss_pkg::status_type  status,
   output bcss_pkg::cmd_type     cmd
);

   bcss_pkg::state_type state_ff;
   bcss_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         bcss_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = bcss_pkg::ST_SCAN;
            end
         end
         bcss_pkg::ST_SCAN: begin
            // A full set drops the item without touching the sample count or group state.
            if (status.full) begin
               state_in = bcss_pkg::ST_IDLE;
            end else if (status.scan_done) begin
               state_in = bcss_pkg::ST_DRAIN;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         bcss_pkg::ST_DRAIN: begin
            if (status.pipe_empty) begin
               state_in = bcss_pkg::ST_DECIDE;
            end
         end
         bcss_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = status.group_close ? bcss_pkg::ST_EMIT : bcss_pkg::ST_IDLE;
         end
         bcss_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = bcss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bcss_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/bcss_datapath.sv
module bcss_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  bcss_pkg::cmd_type                   cmd,
   output bcss_pkg::status_type                status,
   input  logic [bcss_pkg::DIR_W-1:0]          cand_dir,
   input  logic                                new_set,
   input  logic [bcss_pkg::TOTAL_W-1:0]        sample_total,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bcss_pkg::DIR_W+bcss_pkg::INDEX_W-1:0] rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int CW = bcss_pkg::COMP_W;

   // Sample store: z, y, x packed from the top bit down.
   logic [bcss_pkg::DIR_W-1:0] store_mem [bcss_pkg::MAX_SAMPLES];
   logic [bcss_pkg::DIR_W-1:0] rd_ff;

   logic [bcss_pkg::DIR_W-1:0]   cand_ff, cand_in;
   logic [bcss_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [bcss_pkg::COUNT_W-1:0] idx_ff, idx_in;
   logic [bcss_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic signed [bcss_pkg::SCORE_W-1:0] score_ff, score_in;
   logic signed [bcss_pkg::SCORE_W-1:0] best_score_ff, best_score_in;
   logic [bcss_pkg::DIR_W-1:0]   best_dir_ff, best_dir_in;
   logic                         v1_ff, v1_in, v2_ff, v2_in;
   logic signed [bcss_pkg::PROD_W-1:0] px_ff, py_ff, pz_ff;
   logic                         out_valid_ff, out_valid_in;
   logic [bcss_pkg::DIR_W+bcss_pkg::INDEX_W-1:0] out_data_ff, out_data_in;
   logic                         out_last_ff, out_last_in;

   logic [bcss_pkg::COUNT_W-1:0] limit;
   logic signed [bcss_pkg::SUM_W-1:0] dot_sum;
   logic signed [bcss_pkg::SCORE_W-1:0] dot_sat;
   logic [31:0] count_ext;
   logic [bcss_pkg::COUNT_W-1:0] count_next;

   // Effective set size: zero acts as one, clipped to the store depth.
   always_comb begin
      if (sample_total == '0) begin
         limit = bcss_pkg::COUNT_W'(1);
      end else if (32'(sample_total) > bcss_pkg::MAX_SAMPLES) begin
         limit = bcss_pkg::COUNT_W'(bcss_pkg::MAX_SAMPLES);
      end else begin
         limit = bcss_pkg::COUNT_W'(sample_total);
      end
   end

   // Store port: one read per cycle for the scan, one write on emit.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         store_mem[count_ff[bcss_pkg::ADDR_W-1:0]] <= best_dir_ff;
      end
      rd_ff <= store_mem[idx_ff[bcss_pkg::ADDR_W-1:0]];
   end

   // Multiply stage.
   always_ff @(posedge clock) begin
      px_ff <= signed'(rd_ff[CW-1:0]) * signed'(cand_ff[CW-1:0]);
      py_ff <= signed'(rd_ff[2*CW-1:CW]) * signed'(cand_ff[2*CW-1:CW]);
      pz_ff <= signed'(rd_ff[3*CW-1:2*CW]) * signed'(cand_ff[3*CW-1:2*CW]);
   end

   // Sum and saturate to the score range.
   always_comb begin
      dot_sum = bcss_pkg::SUM_W'(px_ff) + bcss_pkg::SUM_W'(py_ff) + bcss_pkg::SUM_W'(pz_ff);
      if (dot_sum > bcss_pkg::SUM_W'(33'sh0_7FFF_FFFF)) begin
         dot_sat = 32'sh7FFF_FFFF;
      end else if (dot_sum < -(bcss_pkg::SUM_W'(33'sh0_8000_0000))) begin
         dot_sat = 32'sh8000_0000;
      end else begin
         dot_sat = dot_sum[bcss_pkg::SCORE_W-1:0];
      end
   end

   assign count_ext = 32'(count_ff);
   assign count_next = count_ff + bcss_pkg::COUNT_W'(1);

   always_comb begin
      cand_in = cand_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      slot_in = slot_ff;
      score_in = score_ff;
      best_score_in = best_score_ff;
      best_dir_in = best_dir_ff;
      v1_in = cmd.issue;
      v2_in = v1_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;

      if (cmd.load) begin
         cand_in = cand_dir;
         idx_in = '0;
         score_in = bcss_pkg::SCORE_MINUS_ONE;
         if (new_set) begin
            count_in = '0;
            slot_in = '0;
            best_score_in = '0;
            best_dir_in = '0;
         end
      end
      if (cmd.issue) begin
         idx_in = idx_ff + bcss_pkg::COUNT_W'(1);
      end
      if (v2_ff && (dot_sat > score_ff)) begin
         score_in = dot_sat;
      end
      if (cmd.decide) begin
         if ((slot_ff == '0) || (score_ff < best_score_ff)) begin
            best_score_in = score_ff;
            best_dir_in = cand_ff;
         end
         slot_in = status.group_close ? '0 : slot_ff + bcss_pkg::SLOT_W'(1);
      end
      if (cmd.emit) begin
         count_in = count_next;
         out_valid_in = 1'b1;
         out_data_in = {count_ext[bcss_pkg::INDEX_W-1:0], best_dir_ff};
         out_last_in = (count_next == limit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         slot_ff <= '0;
         best_score_ff <= '0;
         best_dir_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         slot_ff <= slot_in;
         best_score_ff <= best_score_in;
         best_dir_ff <= best_dir_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      idx_ff <= idx_in;
      score_ff <= score_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      status.full = (count_ff >= limit);
      status.scan_done = (idx_ff == count_ff);
      status.pipe_empty = !v1_ff && !v2_ff;
      status.group_close = (slot_ff == bcss_pkg::SLOT_W'(bcss_pkg::CANDIDATES_PER_SAMPLE - 1));
      status.out_free = !out_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tlast = out_last_ff;

   // The scan never reads beyond the filled part of the store.
   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (idx_ff < count_ff))
      else $error("scan read past the stored samples");

   // A result is never loaded over one that has not been taken.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!out_valid_ff || rsp_tready))
      else $error("result register overwritten");

   // An emit always shows up on the result channel.
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> out_valid_ff)
      else $error("emitted result not presented");

   // The sample count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= bcss_pkg::MAX_SAMPLES)
      else $error("sample count overflow");

   // Decisions are only taken after the dot product pipeline has drained.
   a_decide_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> (!v1_ff && !v2_ff))
      else $error("decision taken with dot products in flight");

endmodule

>>> rtl/best_candidate_sphere_sampler.sv
// Best-candidate sampler for directions on the unit sphere.
// The req channel carries one candidate direction per item: tdata holds
// cand_x, cand_y and cand_z as signed Q1.14, and tuser is the new_set flag,
// which empties the sample set before the candidate is handled. Each
// candidate is scored by the largest dot product against every stored
// sample. After every group of eight candidates, the one with the smallest
// score is stored and sent on the rsp channel with its store index; tlast
// marks the sample that completes the set. Candidates that arrive once the
// set is full give no item.
// After acceptance the block makes one store read per stored sample, sees the
// end of the scan, drains the read and multiply stages and decides. An item
// that closes a group adds an emit step, an empty store finds the pipeline
// already drained, and a candidate that meets a full set goes straight back
// to idle. The next item is accepted once the block is back in idle; one
// item is handled at a time.
// The result waits in an output register; a stalled receiver only holds the
// block when a new result is ready while the previous one is still waiting.
// Reset empties the set and sets sample_total to 256, leaving the store as
// is, since only written entries are read. sample_total sits at csr byte 0.
module best_candidate_sphere_sampler (
   input  logic        clock,
   input  logic        reset,

   // Candidate items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // cand_x [15:0], cand_y [31:16], cand_z [47:32]
   input  logic        req_tuser,   // new_set

   // Chosen sample items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // chosen_x, chosen_y, chosen_z, chosen_index [55:48]
   output logic        rsp_tlast,   // set_full

   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   bcss_pkg::cmd_type    cmd;
   bcss_pkg::status_type status;

   logic [bcss_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic                         reg_index;
   logic                         csr_write;

   // Register index is the word address; every access completes at once.
   assign reg_index = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      total_in = total_ff;
      if (csr_write && (reg_index == bcss_pkg::REG_SAMPLE_TOTAL)) begin
         total_in = csr_pwdata[bcss_pkg::TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= bcss_pkg::TOTAL_RESET;
      end else begin
         total_ff <= total_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         bcss_pkg::REG_SAMPLE_TOTAL: csr_prdata = 32'(total_ff);
         default: csr_prdata = '0;
      endcase
   end

   bcss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bcss_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .cand_dir     (req_tdata),
      .new_set      (req_tuser),
      .sample_total (total_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
